// File: rtl/core/bms_pkg.sv
`timescale 1ns / 1ps

package bms_pkg;

   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_WARN   = 2'd2;
   localparam logic [1:0] FUNC_ENABLE = 2'd3;

   localparam logic [1:0] MEL_POWER_ON  = 2'd0;
   localparam logic [1:0] MEL_POWER_OFF = 2'd1;
   localparam logic [1:0] MEL_SHUTDOWN  = 2'd2;
   localparam logic [1:0] MEL_UNUSED    = 2'd3;

   localparam logic [1:0] WARN_BEEP1 = 2'd0;
   localparam logic [1:0] WARN_GAP   = 2'd1;
   localparam logic [1:0] WARN_BEEP2 = 2'd2;
   localparam logic [1:0] WARN_PAUSE = 2'd3;

   localparam logic CSR_TONE_DUTY = 1'b0;
   localparam logic CSR_WARN_FREQ = 1'b1;

   localparam logic [7:0]  TONE_DUTY_RESET = 8'd64;
   localparam logic [15:0] WARN_FREQ_RESET = 16'd1000;
   localparam logic [15:0] FREQ_RESET      = 16'd2000;

   localparam logic [31:0] WARN_BEEP_MS  = 32'd120;
   localparam logic [31:0] WARN_GAP_MS   = 32'd80;
   localparam logic [31:0] WARN_PAUSE_MS = 32'd700;

   localparam logic [3:0] LAST_SLOT = 4'd10;

   typedef struct packed {
      logic [31:0] ms_clock;
      logic        sound_enabled;
      logic [15:0] cur_freq;
      logic [7:0]  cur_duty;
      logic        playing;
      logic [1:0]  active_melody;
      logic [3:0]  note_pos;
      logic [31:0] note_begin;
      logic        warn_active;
      logic [1:0]  warn_phase;
      logic [31:0] warn_due;
   } bms_state_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [8:0]  dur;
   } bms_note_type;

   function automatic bms_note_type note_lookup(logic [1:0] mel, logic [3:0] pos);
      logic [3:0]   p;
      bms_note_type n;
      p = (pos > LAST_SLOT) ? LAST_SLOT : pos;
      n = '0;
      case (mel)
         MEL_POWER_OFF: begin
            case (p)
               4'd0: n = '{16'd784, 9'd80};
               4'd1: n = '{16'd659, 9'd80};
               4'd2: n = '{16'd523, 9'd80};
               4'd3: n = '{16'd392, 9'd200};
               default: n = '0;
            endcase
         end
         MEL_SHUTDOWN: begin
            case (p)
               4'd0: n = '{16'd800, 9'd100};
               4'd1: n = '{16'd0, 9'd60};
               4'd2: n = '{16'd800, 9'd100};
               4'd3: n = '{16'd0, 9'd60};
               4'd4: n = '{16'd800, 9'd100};
               4'd5: n = '{16'd0, 9'd60};
               4'd6: n = '{16'd600, 9'd150};
               4'd7: n = '{16'd0, 9'd100};
               4'd8: n = '{16'd600, 9'd150};
               4'd9: n = '{16'd0, 9'd100};
               default: n = '{16'd400, 9'd300};
            endcase
         end
         default: begin
            case (p)
               4'd0: n = '{16'd523, 9'd80};
               4'd1: n = '{16'd659, 9'd80};
               4'd2: n = '{16'd784, 9'd80};
               4'd3: n = '{16'd1047, 9'd150};
               default: n = '0;
            endcase
         end
      endcase
      return n;
   endfunction

   function automatic logic [3:0] mel_len(logic [1:0] mel);
      logic [3:0] len;
      case (mel)
         MEL_SHUTDOWN: len = 4'd11;
         default:      len = 4'd4;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/buzzer_melody_sequencer.sv
`timescale 1ns / 1ps

// Buzzer tone sequencer: plays three fixed melodies and a two-beep warning
// pattern (120 ms on, 80 ms off, 120 ms on, 700 ms off).
// Request channel (req_valid / req_stall): func 0 is a one-ms tick, 1 starts
// melody req_melody_select, 2 sets the warning to req_flag, 3 sets sound
// enable to req_flag.
// Response channel (rsp_valid / rsp_stall): one response per request with
// the tone frequency, duty (0 = silent), melody busy and warning status
// after that request.
// A request is held in the request register, then its next state is written
// to the state/response registers. Throughput: one request per cycle while
// rsp_stall is low, set by the single next-state pass between those registers.
// The csr_ port writes tone duty (index 0) and warning frequency (index 1);
// write only while no request is in flight.
// Reset (synchronous) clears both stages and restores duty 64, warning
// frequency 1000 Hz, tone 2000 Hz silent, sound enabled.
// While rsp_stall is high the response holds; one more request is buffered
// and req_stall rises after that.

module buzzer_melody_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_melody_select,
   input  logic        req_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_tone_freq_hz,
   output logic [7:0]  rsp_tone_level,
   output logic        rsp_melody_busy,
   output logic        rsp_warning_on,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic                   pend_ff;
   logic [1:0]             func_ff;
   logic [1:0]             sel_ff;
   logic                   flag_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             tone_duty_ff;
   logic [15:0]            warn_freq_ff;
   bms_pkg::bms_state_type state_ff;
   bms_pkg::bms_state_type state_in;
   logic                   advance;
   logic                   req_take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   bms_step u_step (
      .st            (state_ff),
      .func          (func_ff),
      .melody_select (sel_ff),
      .flag          (flag_ff),
      .tone_duty     (tone_duty_ff),
      .warn_freq_hz  (warn_freq_ff),
      .ns            (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tone_duty_ff <= bms_pkg::TONE_DUTY_RESET;
         warn_freq_ff <= bms_pkg::WARN_FREQ_RESET;
         state_ff     <= '{
            ms_clock:      32'd0,
            sound_enabled: 1'b1,
            cur_freq:      bms_pkg::FREQ_RESET,
            cur_duty:      8'd0,
            playing:       1'b0,
            active_melody: bms_pkg::MEL_POWER_ON,
            note_pos:      4'd0,
            note_begin:    32'd0,
            warn_active:   1'b0,
            warn_phase:    bms_pkg::WARN_BEEP1,
            warn_due:      32'd0
         };
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               bms_pkg::CSR_TONE_DUTY: tone_duty_ff <= csr_wdata[7:0];
               default:                warn_freq_ff <= csr_wdata;
            endcase
         end
         if (advance) begin
            rsp_valid_ff <= pend_ff;
            if (pend_ff) begin
               state_ff <= state_in;
            end
         end
         if (req_take) begin
            pend_ff <= 1'b1;
         end else if (advance) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_func;
         sel_ff  <= req_melody_select;
         flag_ff <= req_flag;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tone_freq_hz = state_ff.cur_freq;
   assign rsp_tone_level   = state_ff.cur_duty;
   assign rsp_melody_busy  = state_ff.playing;
   assign rsp_warning_on   = state_ff.warn_active;

endmodule

// File: rtl/core/bms_step.sv
`timescale 1ns / 1ps

module bms_step (
   input  bms_pkg::bms_state_type st,
   input  logic [1:0]             func,
   input  logic [1:0]             melody_select,
   input  logic                   flag,
   input  logic [7:0]             tone_duty,
   input  logic [15:0]            warn_freq_hz,
   output bms_pkg::bms_state_type ns
);

   logic [31:0]           ms_inc;
   logic [31:0]           note_age;
   logic [3:0]            pos_inc;
   bms_pkg::bms_note_type note_cur;
   bms_pkg::bms_note_type note_next;
   bms_pkg::bms_note_type note_first;

   assign ms_inc     = st.ms_clock + 32'd1;
   assign note_age   = ms_inc - st.note_begin;
   assign pos_inc    = st.note_pos + 4'd1;
   assign note_cur   = bms_pkg::note_lookup(st.active_melody, st.note_pos);
   assign note_next  = bms_pkg::note_lookup(st.active_melody, pos_inc);
   assign note_first = bms_pkg::note_lookup(melody_select, 4'd0);

   always_comb begin
      ns = st;
      case (func)
         bms_pkg::FUNC_TICK: begin
            ns.ms_clock = ms_inc;
            if (st.warn_active && !st.playing && !(ms_inc < st.warn_due)) begin
               case (st.warn_phase)
                  bms_pkg::WARN_BEEP1: begin
                     if (st.sound_enabled) begin
                        ns.cur_freq = warn_freq_hz;
                        ns.cur_duty = tone_duty;
                     end
                     ns.warn_due   = ms_inc + bms_pkg::WARN_BEEP_MS;
                     ns.warn_phase = bms_pkg::WARN_GAP;
                  end
                  bms_pkg::WARN_GAP: begin
                     ns.cur_duty   = '0;
                     ns.warn_due   = ms_inc + bms_pkg::WARN_GAP_MS;
                     ns.warn_phase = bms_pkg::WARN_BEEP2;
                  end
                  bms_pkg::WARN_BEEP2: begin
                     if (st.sound_enabled) begin
                        ns.cur_freq = warn_freq_hz;
                        ns.cur_duty = tone_duty;
                     end
                     ns.warn_due   = ms_inc + bms_pkg::WARN_BEEP_MS;
                     ns.warn_phase = bms_pkg::WARN_PAUSE;
                  end
                  default: begin
                     ns.cur_duty   = '0;
                     ns.warn_due   = ms_inc + bms_pkg::WARN_PAUSE_MS;
                     ns.warn_phase = bms_pkg::WARN_BEEP1;
                  end
               endcase
            end
            if (st.playing && (note_age >= {23'd0, note_cur.dur})) begin
               ns.note_pos = pos_inc;
               if (pos_inc >= bms_pkg::mel_len(st.active_melody)) begin
                  ns.cur_duty = '0;
                  ns.playing  = 1'b0;
               end else begin
                  ns.note_begin = ms_inc;
                  if (note_next.freq != 16'd0) begin
                     if (st.sound_enabled) begin
                        ns.cur_freq = note_next.freq;
                        ns.cur_duty = tone_duty;
                     end
                  end else begin
                     ns.cur_duty = '0;
                  end
               end
            end
         end
         bms_pkg::FUNC_START: begin
            if (st.sound_enabled && (melody_select != bms_pkg::MEL_UNUSED)) begin
               ns.active_melody = melody_select;
               ns.note_pos      = '0;
               ns.playing       = 1'b1;
               ns.note_begin    = st.ms_clock;
               if (note_first.freq != 16'd0) begin
                  ns.cur_freq = note_first.freq;
                  ns.cur_duty = tone_duty;
               end else begin
                  ns.cur_duty = '0;
               end
            end
         end
         bms_pkg::FUNC_WARN: begin
            if (flag != st.warn_active) begin
               ns.warn_active = flag;
               ns.warn_phase  = bms_pkg::WARN_BEEP1;
               if (!flag) begin
                  ns.cur_duty = '0;
               end else begin
                  ns.warn_due = st.ms_clock;
               end
            end
         end
         default: begin
            if (flag != st.sound_enabled) begin
               ns.sound_enabled = flag;
               if (!flag) begin
                  ns.cur_duty = '0;
                  ns.playing  = 1'b0;
               end
            end
         end
      endcase
   end

endmodule

// File: rtl/core/bms_checker.sv
`timescale 1ns / 1ps

module bms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_tone_freq_hz,
   input logic [7:0]  rsp_tone_level,
   input logic        rsp_melody_busy,
   input logic        rsp_warning_on
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty response stage");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response drains");

   a_hold_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tone_freq_hz)
         && $stable(rsp_tone_level) && $stable(rsp_melody_busy)
         && $stable(rsp_warning_on))
      else $error("stalled response changed");

   a_sound_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tone_level != 8'd0) |-> rsp_melody_busy || rsp_warning_on)
      else $error("tone sounds with no melody or warning");

endmodule

bind buzzer_melody_sequencer bms_checker u_bms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_tone_freq_hz (rsp_tone_freq_hz),
   .rsp_tone_level   (rsp_tone_level),
   .rsp_melody_busy  (rsp_melody_busy),
   .rsp_warning_on   (rsp_warning_on)
);

// File: sim/tb_buzzer_melody_sequencer.sv
`timescale 1ns / 1ps

module tb_buzzer_melody_sequencer;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_REQS  = 30;

   typedef struct packed {
      logic [15:0] freq;
      logic [7:0]  level;
      logic        busy;
      logic        alarm;
   } tone_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [1:0]  req_melody_select;
   logic        req_flag;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_tone_freq_hz;
   logic [7:0]  rsp_tone_level;
   logic        rsp_melody_busy;
   logic        rsp_warning_on;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   buzzer_melody_sequencer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_melody_select (req_melody_select),
      .req_flag          (req_flag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tone_freq_hz  (rsp_tone_freq_hz),
      .rsp_tone_level    (rsp_tone_level),
      .rsp_melody_busy   (rsp_melody_busy),
      .rsp_warning_on    (rsp_warning_on),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // tone model
   logic [7:0]  duty_cfg;
   logic [15:0] beep_hz;
   logic [31:0] now_ms;
   logic        snd_en;
   logic [15:0] freq_now;
   logic [7:0]  duty_now;
   logic        mel_run;
   logic [1:0]  mel_id;
   logic [3:0]  slot;
   logic [31:0] slot_start;
   logic        alarm_on;
   logic [1:0]  alarm_step;
   logic [31:0] alarm_at;

   tone_type tone_q[$];
   tone_type want;

   int  errors;
   int  sent_count;
   int  req_seen;
   int  rsp_checked;
   int  songs_done;
   int  beeps;
   int  cycle_count;
   bit  idle_on;

   always #10 clock = ~clock;

   function automatic logic [31:0] song_step(input logic [1:0] m, input logic [3:0] p);
      logic [3:0]  q;
      logic [31:0] hz_ms;
      q = (p > bms_pkg::LAST_SLOT) ? bms_pkg::LAST_SLOT : p;
      hz_ms = '0;
      case ({m, q})
         {bms_pkg::MEL_POWER_ON, 4'd0}:  hz_ms = {16'd523, 16'd80};
         {bms_pkg::MEL_POWER_ON, 4'd1}:  hz_ms = {16'd659, 16'd80};
         {bms_pkg::MEL_POWER_ON, 4'd2}:  hz_ms = {16'd784, 16'd80};
         {bms_pkg::MEL_POWER_ON, 4'd3}:  hz_ms = {16'd1047, 16'd150};
         {bms_pkg::MEL_POWER_OFF, 4'd0}: hz_ms = {16'd784, 16'd80};
         {bms_pkg::MEL_POWER_OFF, 4'd1}: hz_ms = {16'd659, 16'd80};
         {bms_pkg::MEL_POWER_OFF, 4'd2}: hz_ms = {16'd523, 16'd80};
         {bms_pkg::MEL_POWER_OFF, 4'd3}: hz_ms = {16'd392, 16'd200};
         {bms_pkg::MEL_SHUTDOWN, 4'd0}:  hz_ms = {16'd800, 16'd100};
         {bms_pkg::MEL_SHUTDOWN, 4'd1}:  hz_ms = {16'd0, 16'd60};
         {bms_pkg::MEL_SHUTDOWN, 4'd2}:  hz_ms = {16'd800, 16'd100};
         {bms_pkg::MEL_SHUTDOWN, 4'd3}:  hz_ms = {16'd0, 16'd60};
         {bms_pkg::MEL_SHUTDOWN, 4'd4}:  hz_ms = {16'd800, 16'd100};
         {bms_pkg::MEL_SHUTDOWN, 4'd5}:  hz_ms = {16'd0, 16'd60};
         {bms_pkg::MEL_SHUTDOWN, 4'd6}:  hz_ms = {16'd600, 16'd150};
         {bms_pkg::MEL_SHUTDOWN, 4'd7}:  hz_ms = {16'd0, 16'd100};
         {bms_pkg::MEL_SHUTDOWN, 4'd8}:  hz_ms = {16'd600, 16'd150};
         {bms_pkg::MEL_SHUTDOWN, 4'd9}:  hz_ms = {16'd0, 16'd100};
         {bms_pkg::MEL_SHUTDOWN, 4'd10}: hz_ms = {16'd400, 16'd300};
         default:                        hz_ms = '0;
      endcase
      return hz_ms;
   endfunction

   function automatic logic [3:0] song_len(input logic [1:0] m);
      return (m == bms_pkg::MEL_SHUTDOWN) ? 4'd11 : 4'd4;
   endfunction

   task automatic reset_tone_model();
      duty_cfg   = bms_pkg::TONE_DUTY_RESET;
      beep_hz    = bms_pkg::WARN_FREQ_RESET;
      now_ms     = '0;
      snd_en     = 1'b1;
      freq_now   = bms_pkg::FREQ_RESET;
      duty_now   = '0;
      mel_run    = 1'b0;
      mel_id     = bms_pkg::MEL_POWER_ON;
      slot       = '0;
      slot_start = '0;
      alarm_on   = 1'b0;
      alarm_step = bms_pkg::WARN_BEEP1;
      alarm_at   = '0;
   endtask

   task automatic sound(input logic [15:0] hz);
      if (snd_en) begin
         freq_now = hz;
         duty_now = duty_cfg;
      end
   endtask

   task automatic play_slot();
      logic [31:0] hz_ms;
      hz_ms = song_step(mel_id, slot);
      if (hz_ms[31:16] != 16'd0) sound(hz_ms[31:16]);
      else duty_now = '0;
   endtask

   task automatic alarm_tick();
      if (alarm_on && !mel_run && now_ms >= alarm_at) begin
         case (alarm_step)
            bms_pkg::WARN_BEEP1: begin
               sound(beep_hz);
               alarm_at   = now_ms + bms_pkg::WARN_BEEP_MS;
               alarm_step = bms_pkg::WARN_GAP;
               beeps++;
            end
            bms_pkg::WARN_GAP: begin
               duty_now   = '0;
               alarm_at   = now_ms + bms_pkg::WARN_GAP_MS;
               alarm_step = bms_pkg::WARN_BEEP2;
            end
            bms_pkg::WARN_BEEP2: begin
               sound(beep_hz);
               alarm_at   = now_ms + bms_pkg::WARN_BEEP_MS;
               alarm_step = bms_pkg::WARN_PAUSE;
               beeps++;
            end
            default: begin
               duty_now   = '0;
               alarm_at   = now_ms + bms_pkg::WARN_PAUSE_MS;
               alarm_step = bms_pkg::WARN_BEEP1;
            end
         endcase
      end
   endtask

   task automatic melody_tick();
      logic [31:0] hz_ms;
      if (mel_run) begin
         hz_ms = song_step(mel_id, slot);
         if (now_ms - slot_start >= {16'd0, hz_ms[15:0]}) begin
            slot = slot + 4'd1;
            if (slot >= song_len(mel_id)) begin
               duty_now = '0;
               mel_run  = 1'b0;
               songs_done++;
            end else begin
               slot_start = now_ms;
               play_slot();
            end
         end
      end
   endtask

   task automatic step_tone(input logic [1:0] f, input logic [1:0] sel, input logic flg);
      case (f)
         bms_pkg::FUNC_TICK: begin
            now_ms = now_ms + 32'd1;
            alarm_tick();
            melody_tick();
         end
         bms_pkg::FUNC_START: begin
            if (snd_en && sel != bms_pkg::MEL_UNUSED) begin
               mel_id     = sel;
               slot       = '0;
               mel_run    = 1'b1;
               slot_start = now_ms;
               play_slot();
            end
         end
         bms_pkg::FUNC_WARN: begin
            if (flg != alarm_on) begin
               alarm_on   = flg;
               alarm_step = bms_pkg::WARN_BEEP1;
               if (!flg) duty_now = '0;
               else alarm_at = now_ms;
            end
         end
         default: begin
            if (flg != snd_en) begin
               snd_en = flg;
               if (!flg) begin
                  duty_now = '0;
                  mel_run  = 1'b0;
               end
            end
         end
      endcase
      tone_q.push_back('{freq: freq_now, level: duty_now, busy: mel_run, alarm: alarm_on});
   endtask

   task automatic report(input string what);
      if (errors < 40) $display("ERROR at %0t: %s", $time, what);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         step_tone(req_func, req_melody_select, req_flag);
         req_seen++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tone_q.size() == 0) begin
            report("response with nothing pending");
         end else begin
            want = tone_q.pop_front();
            if (rsp_tone_freq_hz !== want.freq)
               report($sformatf("response %0d: tone_freq_hz %0d, want %0d",
                                rsp_checked, rsp_tone_freq_hz, want.freq));
            if (rsp_tone_level !== want.level)
               report($sformatf("response %0d: tone_level %0d, want %0d",
                                rsp_checked, rsp_tone_level, want.level));
            if (rsp_melody_busy !== want.busy)
               report($sformatf("response %0d: melody_busy %0b, want %0b",
                                rsp_checked, rsp_melody_busy, want.busy));
            if (rsp_warning_on !== want.alarm)
               report($sformatf("response %0d: warning_on %0b, want %0b",
                                rsp_checked, rsp_warning_on, want.alarm));
         end
         rsp_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count, tone_q.size());
         $display("buzzer_melody_sequencer: mismatch");
         $finish;
      end
   end

   // hold the response side in random bursts
   always begin
      @(posedge clock);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_req(input logic [1:0] f, input logic [1:0] sel, input logic flg);
      req_valid         <= 1'b1;
      req_func          <= f;
      req_melody_select <= sel;
      req_flag          <= flg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic tick(input int n);
      repeat (n) send_req(bms_pkg::FUNC_TICK, 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
   endtask

   task automatic send_noise();
      send_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
   endtask

   task automatic tick_noisy(input int n, input int rate, input int stop_at);
      repeat (n) begin
         if (sent_count < stop_at) begin
            if ($urandom_range(0, rate) == 0) send_noise();
            else tick(1);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tone_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] data);
      csr_index    <= idx;
      csr_wdata    <= data;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == bms_pkg::CSR_TONE_DUTY) duty_cfg = data[7:0];
      else beep_hz = data;
   endtask

   task automatic test_directed();
      tick(1);
      send_req(bms_pkg::FUNC_START, bms_pkg::MEL_POWER_ON, 1'b0);
      tick(3);
      send_req(bms_pkg::FUNC_START, bms_pkg::MEL_UNUSED, 1'b1);
      send_req(bms_pkg::FUNC_ENABLE, bms_pkg::MEL_UNUSED, 1'b1);
      send_req(bms_pkg::FUNC_ENABLE, bms_pkg::MEL_POWER_ON, 1'b0);
      send_req(bms_pkg::FUNC_START, bms_pkg::MEL_SHUTDOWN, 1'b1);
      send_req(bms_pkg::FUNC_WARN, bms_pkg::MEL_POWER_OFF, 1'b1);
      tick(1);
      send_req(bms_pkg::FUNC_WARN, bms_pkg::MEL_POWER_ON, 1'b1);
      send_req(bms_pkg::FUNC_ENABLE, bms_pkg::MEL_SHUTDOWN, 1'b1);
      tick(1);
      send_req(bms_pkg::FUNC_START, bms_pkg::MEL_POWER_OFF, 1'b0);
      tick(1);
      send_req(bms_pkg::FUNC_WARN, bms_pkg::MEL_UNUSED, 1'b0);
      send_req(bms_pkg::FUNC_WARN, bms_pkg::MEL_POWER_OFF, 1'b0);
      send_req(bms_pkg::FUNC_START, bms_pkg::MEL_SHUTDOWN, 1'b0);
      tick(1);
      send_req(bms_pkg::FUNC_ENABLE, bms_pkg::MEL_POWER_ON, 1'b0);
      send_req(bms_pkg::FUNC_ENABLE, bms_pkg::MEL_UNUSED, 1'b0);
      send_req(bms_pkg::FUNC_ENABLE, bms_pkg::MEL_POWER_OFF, 1'b1);
      tick(1);
      drain();
   endtask

   task automatic test_shutdown_with_warning();
      send_req(bms_pkg::FUNC_WARN, bms_pkg::MEL_POWER_ON, 1'b1);
      tick(5);
      send_req(bms_pkg::FUNC_START, bms_pkg::MEL_SHUTDOWN, 1'b0);
      tick(1285);
      tick(210);
      send_req(bms_pkg::FUNC_WARN, bms_pkg::MEL_POWER_ON, 1'b0);
      drain();
   endtask

   task automatic test_random_phase(input logic [7:0] duty, input logic [15:0] hz,
                                    input bit quiet);
      int stop;
      int kind;
      write_reg(bms_pkg::CSR_TONE_DUTY, {8'($urandom_range(0, 255)), duty});
      write_reg(bms_pkg::CSR_WARN_FREQ, hz);
      if (quiet) idle_on = 1'b0;
      stop = sent_count + PHASE_REQS;
      while (sent_count < stop) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            if ($urandom_range(0, 3) != 0)
               send_req(bms_pkg::FUNC_ENABLE, 2'($urandom_range(0, 3)), 1'b1);
            send_req(bms_pkg::FUNC_START,
                     ($urandom_range(0, 9) == 0) ? bms_pkg::MEL_UNUSED
                                                 : 2'($urandom_range(0, 2)),
                     1'($urandom_range(0, 1)));
            tick_noisy($urandom_range(20, 450), 60, stop);
         end else if (kind <= 7) begin
            send_req(bms_pkg::FUNC_WARN, 2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0);
            tick_noisy($urandom_range(100, 500), 40, stop);
         end else if (kind == 8) begin
            send_req(bms_pkg::FUNC_ENABLE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            tick_noisy($urandom_range(5, 50), 10, stop);
         end else begin
            repeat ($urandom_range(5, 20)) send_noise();
         end
      end
      drain();
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = bms_pkg::FUNC_TICK;
      req_melody_select = bms_pkg::MEL_POWER_ON;
      req_flag          = 1'b0;
      rsp_stall         = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = bms_pkg::CSR_TONE_DUTY;
      csr_wdata         = '0;
      errors            = 0;
      sent_count        = 0;
      req_seen          = 0;
      rsp_checked       = 0;
      songs_done        = 0;
      beeps             = 0;
      cycle_count       = 0;
      idle_on           = 1'b0;
      reset_tone_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      test_directed();
      test_shutdown_with_warning();
      test_random_phase(8'd255, 16'd65535, 1'b0);
      test_random_phase(8'd0, 16'd1, 1'b0);
      test_random_phase(8'($urandom_range(1, 254)), 16'd0, 1'b0);
      test_random_phase(8'($urandom_range(0, 255)), 16'($urandom_range(2, 65534)), 1'b1);

      drain();
      $display("%0d requests sent, %0d responses checked over five register settings",
               req_seen, rsp_checked);
      $display("%0d melodies played to the end, %0d warning beeps", songs_done, beeps);
      if (errors == 0) begin
         $display("buzzer_melody_sequencer: match");
      end else begin
         $display("%0d mismatches", errors);
         $display("buzzer_melody_sequencer: mismatch");
      end
      $finish;
   end

endmodule
